// ===== hdl/seos_pkg.sv =====
// Shared types, result codes and key compare for the sorted event overlap sweep.
`timescale 1ns / 1ps

package seos_pkg;

    localparam int SEC_W  = 32;
    localparam int MS_W   = 10;
    localparam int KIND_W = 3;
    localparam int RUN_W  = 8;

    // Command codes of an input transaction.
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_SWEEP  = 1'b1;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_INSERTED = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DROPPED  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_OPEN     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CLOSE    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NONE     = 3'd4;

    // Running count levels at which an overlap opens and closes.
    localparam logic [RUN_W-1:0] OVERLAP_LEVEL = 8'd2;
    localparam logic [RUN_W-1:0] OVERLAP_EXIT  = 8'd1;

    typedef struct packed {
        logic             stop;
        logic [SEC_W-1:0] sec;
        logic [MS_W-1:0]  ms;
    } entry_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SEC_W-1:0]  sec;
        logic [MS_W-1:0]   ms;
        logic              last;
    } result_t;

    // True when the key of a is strictly below the key of b.
    function automatic logic key_less(entry_t a, entry_t b);
        return (a.sec < b.sec) || ((a.sec == b.sec) && (a.ms < b.ms));
    endfunction

endpackage

// ===== hdl/seos_in_if.sv =====
// Input channel: event insert and sweep commands.
`timescale 1ns / 1ps

interface seos_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic        is_stop;
    logic [31:0] event_seconds;
    logic [9:0]  event_millis;

    modport source (output valid, command, is_stop, event_seconds, event_millis, input ready);
    modport sink   (input valid, command, is_stop, event_seconds, event_millis, output ready);
endinterface

// ===== hdl/seos_out_if.sv =====
// Output channel: inserted, dropped, overlap and none-found results.
`timescale 1ns / 1ps

interface seos_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] time_seconds;
    logic [9:0]  time_millis;
    logic        last;

    modport source (output valid, kind, time_seconds, time_millis, last, input ready);
    modport sink   (input valid, kind, time_seconds, time_millis, last, output ready);
endinterface

// ===== hdl/seos_mem.sv =====
// Event table memory: one write port, one registered read port.
`timescale 1ns / 1ps

module seos_mem
    import seos_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read data holds between reads so a stalled consumer can keep using it.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/seos_result_reg.sv =====
// Output register that holds one result transaction until the sink takes it.
`timescale 1ns / 1ps

module seos_result_reg
    import seos_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  result_t    load_data,
    output logic       slot_free,
    seos_out_if.source res
);

    logic    valid_reg;
    result_t data_reg;

    assign slot_free = !valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign res.valid        = valid_reg;
    assign res.kind         = data_reg.kind;
    assign res.time_seconds = data_reg.sec;
    assign res.time_millis  = data_reg.ms;
    assign res.last         = data_reg.last;

endmodule

// ===== hdl/sorted_event_overlap_sweep.sv =====
// Top level of the sorted event table with overlap sweep.
//
//  channel | modport | transaction
//  --------+---------+------------------------------------------------------------
//  evt     | sink    | command, is_stop, event_seconds, event_millis
//  res     | source  | kind, time_seconds, time_millis, last (last ends an item)
//
// An insert of an event into a table walks it downwards from its top entry, one entry
// per cycle through the single read port of the table memory, each larger entry being
// moved up by one; an event below every entry takes a further state to write the bottom
// entry, and an empty or full table skips the walk.
// A sweep reads the table upwards from the bottom entry, one entry per cycle through
// the same read port, unless a hit finds a result pending and the output register held.
// Either waits to finish while the output register is held by the sink.
// Reset clears the entry count, the controller state, the running count and the
// pending flag; the memory itself is not cleared, as only entries below the count are read.
// New transactions are accepted only while the controller is idle, but a finished
// result may still be waiting in the output register at that time.
`timescale 1ns / 1ps

module sorted_event_overlap_sweep
    import seos_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    seos_in_if.sink    evt,
    seos_out_if.source res
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // Controller states.
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_INS_WALK = 3'd1;
    localparam logic [2:0] ST_INS_HEAD = 3'd2;
    localparam logic [2:0] ST_SWEEP    = 3'd3;
    localparam logic [2:0] ST_SW_END   = 3'd4;
    localparam logic [2:0] ST_REPORT   = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [RUN_W-1:0]  run_reg, run_next;
    entry_t            item_reg, item_next;
    result_t           pend_reg, pend_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [KIND_W-1:0] report_kind_reg, report_kind_next;

    // Table memory ports.
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    entry_t        rd_data;

    // Output register ports.
    logic    out_load;
    result_t out_data;
    logic    slot_free;

    // Sweep datapath.
    logic [RUN_W-1:0] run_step;
    logic             sweep_hit;
    result_t          sweep_result;
    logic [AW-1:0]    top_idx;
    entry_t           evt_entry;

    seos_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    seos_result_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .load_data (out_data),
        .slot_free (slot_free),
        .res       (res)
    );

    assign evt.ready = (state_reg == ST_IDLE);

    assign evt_entry = '{stop: evt.is_stop, sec: evt.event_seconds, ms: evt.event_millis};

    // Index of the highest occupied entry; only used while the table is not empty.
    assign top_idx = AW'(count_reg - CW'(1));

    // A start adds one to the running count and a stop takes one away.
    assign run_step  = rd_data.stop ? (run_reg - RUN_W'(1)) : (run_reg + RUN_W'(1));
    assign sweep_hit = (!rd_data.stop && (run_step == OVERLAP_LEVEL)) ||
                       (rd_data.stop && (run_step == OVERLAP_EXIT));
    assign sweep_result = '{kind: (rd_data.stop ? KIND_CLOSE : KIND_OPEN),
                            sec: rd_data.sec, ms: rd_data.ms, last: 1'b0};

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        run_next         = run_reg;
        item_next        = item_reg;
        pend_next        = pend_reg;
        pend_valid_next  = pend_valid_reg;
        report_kind_next = report_kind_reg;
        wr_en            = 1'b0;
        wr_addr          = '0;
        wr_data          = item_reg;
        rd_en            = 1'b0;
        rd_addr          = idx_reg;
        out_load         = 1'b0;
        out_data         = '{kind: report_kind_reg, sec: '0, ms: '0, last: 1'b1};

        case (state_reg)
            ST_IDLE:
            begin
                if (evt.valid)
                begin
                    item_next = evt_entry;
                    if (evt.command == CMD_INSERT)
                    begin
                        if (count_reg == CW'(TABLE_DEPTH))
                        begin
                            report_kind_next = KIND_DROPPED;
                            state_next       = ST_REPORT;
                        end
                        else if (count_reg == '0)
                        begin
                            // Empty table: the event goes straight to the bottom entry.
                            wr_en            = 1'b1;
                            wr_addr          = '0;
                            wr_data          = evt_entry;
                            count_next       = count_reg + CW'(1);
                            report_kind_next = KIND_INSERTED;
                            state_next       = ST_REPORT;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = top_idx;
                            idx_next   = top_idx;
                            state_next = ST_INS_WALK;
                        end
                    end
                    else
                    begin
                        run_next        = '0;
                        pend_valid_next = 1'b0;
                        if (count_reg == '0)
                        begin
                            report_kind_next = KIND_NONE;
                            state_next       = ST_REPORT;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            idx_next   = '0;
                            state_next = ST_SWEEP;
                        end
                    end
                end
            end

            ST_INS_WALK:
            begin
                // rd_data is entry idx_reg. A strictly larger entry moves up one place;
                // an equal or smaller one marks where the new event lands, so equal keys
                // keep their arrival order.
                if (key_less(item_reg, rd_data))
                begin
                    wr_en   = 1'b1;
                    wr_addr = idx_reg + AW'(1);
                    wr_data = rd_data;
                    if (idx_reg == '0)
                    begin
                        state_next = ST_INS_HEAD;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg - AW'(1);
                        idx_next = idx_reg - AW'(1);
                    end
                end
                else
                begin
                    wr_en            = 1'b1;
                    wr_addr          = idx_reg + AW'(1);
                    wr_data          = item_reg;
                    count_next       = count_reg + CW'(1);
                    report_kind_next = KIND_INSERTED;
                    state_next       = ST_REPORT;
                end
            end

            ST_INS_HEAD:
            begin
                wr_en            = 1'b1;
                wr_addr          = '0;
                wr_data          = item_reg;
                count_next       = count_reg + CW'(1);
                report_kind_next = KIND_INSERTED;
                state_next       = ST_REPORT;
            end

            ST_SWEEP:
            begin
                // The newest overlap result is held back in pend_reg so that the final
                // one can be marked last. A hit with a result already pending needs the
                // output register; otherwise the walk waits with the read data held.
                if (!(sweep_hit && pend_valid_reg && !slot_free))
                begin
                    run_next = run_step;
                    if (sweep_hit)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_load = 1'b1;
                            out_data = pend_reg;
                        end
                        pend_next       = sweep_result;
                        pend_valid_next = 1'b1;
                    end
                    if (idx_reg == top_idx)
                    begin
                        state_next = ST_SW_END;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg + AW'(1);
                        idx_next = idx_reg + AW'(1);
                    end
                end
            end

            ST_SW_END:
            begin
                if (slot_free)
                begin
                    out_load = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_data      = pend_reg;
                        out_data.last = 1'b1;
                    end
                    else
                    begin
                        out_data = '{kind: KIND_NONE, sec: '0, ms: '0, last: 1'b1};
                    end
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            ST_REPORT:
            begin
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            count_reg       <= '0;
            run_reg         <= '0;
            pend_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            run_reg         <= run_next;
            pend_valid_reg  <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        item_reg        <= item_next;
        pend_reg        <= pend_next;
        report_kind_reg <= report_kind_next;
    end

endmodule

// ===== hdl/seos_checker.sv =====
// Port-level checks for the sorted event overlap sweep, bound to the top level.
`timescale 1ns / 1ps

module seos_checker
    import seos_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              evt_valid,
    input logic              evt_ready,
    input logic              res_valid,
    input logic              res_ready,
    input logic [KIND_W-1:0] res_kind,
    input logic [SEC_W-1:0]  res_seconds,
    input logic [MS_W-1:0]   res_millis,
    input logic              res_last
);

    // A result waiting for the sink stays in place.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_kind) && $stable(res_seconds)
                                    && $stable(res_millis) && $stable(res_last))
    else $error("result changed while stalled");

    // Every accepted transaction takes the controller out of idle, so no input is accepted back to back.
    assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_ready |=> !evt_ready)
    else $error("input accepted in back-to-back cycles");

    // Insert, drop and none-found results are single, final and carry no time.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_kind == KIND_INSERTED || res_kind == KIND_DROPPED ||
                      res_kind == KIND_NONE)
        |-> res_last && (res_seconds == '0) && (res_millis == '0))
    else $error("report result malformed");

endmodule

bind sorted_event_overlap_sweep seos_checker u_seos_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .evt_valid   (evt.valid),
    .evt_ready   (evt.ready),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .res_kind    (res.kind),
    .res_seconds (res.time_seconds),
    .res_millis  (res.time_millis),
    .res_last    (res.last)
);
